FILE: src/bpd_pkg.sv
// Shared types and constants for the bidirectional PID PWM drive.
package bpd_pkg;

	localparam int TEMP_W   = 15;
	localparam int TGT_W    = 7;
	localparam int GAIN_W   = 16;
	localparam int THR_W    = 7;
	localparam int ERR_W    = 17;
	localparam int INTEG_W  = 16;
	localparam int DERIV_W  = 18;
	localparam int ADD_W    = 20;
	localparam int ACC_W    = 35;
	localparam int MAG_W    = 23;
	localparam int DUTY_W   = 15;
	localparam int PWM_BITS = 10;
	localparam int DVD_W    = PWM_BITS + DUTY_W - 8;
	localparam int REM_W    = 7;

	localparam logic [PWM_BITS-1:0] PWM_MAX = {PWM_BITS{1'b1}};

	// register indexes on the configuration port
	localparam int IDX_W = 2;
	localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 2'd2;
	localparam logic [IDX_W-1:0] REG_COOL_THR   = 2'd3;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd12800;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
	localparam logic [THR_W-1:0]  COOL_THR_RST   = 7'd10;

	localparam logic signed [INTEG_W+1:0] INTEG_HI = 18'sd25600;
	localparam logic signed [INTEG_W+1:0] INTEG_LO = -18'sd25600;
	localparam logic signed [ACC_W-1:0]   DRIVE_HI = 35'sd6488064;
	localparam logic signed [ACC_W-1:0]   DRIVE_LO = -35'sd6488064;
	localparam logic [MAG_W-1:0]          DRIVE_MAG = 23'd6488064;
	localparam logic [TEMP_W:0]           GAP_LIMIT = 16'd15360;
	localparam logic [REM_W:0]            PCT_DIV   = 8'd100;

	typedef struct packed {
		logic [TEMP_W-1:0] chamber_temp;
		logic [TEMP_W-1:0] sink_temp;
		logic [TGT_W-1:0]  setpoint;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   duty_magnitude;
		logic                drive_direction;
		logic [PWM_BITS-1:0] pwm_count;
	} out_item_t;

endpackage

FILE: src/bpd_serial_mac.sv
// Bit-serial triple multiply-accumulate over the gain bits, MSB first.
module bpd_serial_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [bpd_pkg::GAIN_W-1:0]             prop_gain,
	input  logic [bpd_pkg::GAIN_W-1:0]             integ_gain,
	input  logic [bpd_pkg::GAIN_W-1:0]             deriv_gain,
	input  logic signed [bpd_pkg::ERR_W-1:0]       err,
	input  logic signed [bpd_pkg::INTEG_W-1:0]     integ,
	input  logic signed [bpd_pkg::DERIV_W-1:0]     deriv,
	output logic                                   last,
	output logic signed [bpd_pkg::ACC_W-1:0]       acc
);

	localparam int CNT_W = $clog2(bpd_pkg::GAIN_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bpd_pkg::GAIN_W - 1);

	logic                              busy_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [bpd_pkg::GAIN_W-1:0]        gp_q, gi_q, gd_q;
	logic signed [bpd_pkg::ACC_W-1:0]  acc_q;
	logic signed [bpd_pkg::ADD_W-1:0]  addend;

	always_comb begin
		addend = '0;
		if (gp_q[bpd_pkg::GAIN_W-1])
			addend = addend + bpd_pkg::ADD_W'(err);
		if (gi_q[bpd_pkg::GAIN_W-1])
			addend = addend + bpd_pkg::ADD_W'(integ);
		if (gd_q[bpd_pkg::GAIN_W-1])
			addend = addend + bpd_pkg::ADD_W'(deriv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gp_q  <= prop_gain;
			gi_q  <= integ_gain;
			gd_q  <= deriv_gain;
			acc_q <= '0;
		end else if (busy_q) begin
			gp_q  <= gp_q << 1;
			gi_q  <= gi_q << 1;
			gd_q  <= gd_q << 1;
			acc_q <= (acc_q <<< 1) + bpd_pkg::ACC_W'(addend);
		end
	end

	assign last = busy_q && (cnt_q == CNT_LAST);
	assign acc  = acc_q;

endmodule

FILE: src/bpd_pwm_div.sv
// Restoring division of the scaled duty by one hundred, one quotient bit a cycle.
module bpd_pwm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bpd_pkg::DUTY_W-1:0]        duty,
	output logic                              last,
	output logic [bpd_pkg::PWM_BITS-1:0]      quotient
);

	localparam int FULL_W = bpd_pkg::DUTY_W + bpd_pkg::PWM_BITS;
	localparam int CNT_W  = $clog2(bpd_pkg::DVD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bpd_pkg::DVD_W - 1);

	logic                           busy_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [bpd_pkg::DVD_W-1:0]      dvd_q;
	logic [bpd_pkg::REM_W-1:0]      rem_q;
	logic [FULL_W-1:0]              scaled;
	logic [bpd_pkg::REM_W:0]        trial;
	logic                           qbit;

	// duty * (2^N - 1), then drop the Q8 fraction; the rest is a divide by 100
	assign scaled = {duty, {bpd_pkg::PWM_BITS{1'b0}}} - FULL_W'(duty);
	assign trial  = {rem_q, dvd_q[bpd_pkg::DVD_W-1]};
	assign qbit   = (trial >= bpd_pkg::PCT_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST)
				busy_q <= 1'b0;
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= scaled[FULL_W-1:8];
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bpd_pkg::DVD_W-2:0], qbit};
			if (qbit) begin
				rem_q <= bpd_pkg::REM_W'(trial - bpd_pkg::PCT_DIV);
			end else begin
				rem_q <= trial[bpd_pkg::REM_W-1:0];
			end
		end
	end

	assign last     = busy_q && (cnt_q == CNT_LAST);
	assign quotient = dvd_q[bpd_pkg::PWM_BITS-1:0];

endmodule

FILE: src/bidirectional_pid_pwm_drive.sv
// Bidirectional PID drive: one sample in, one duty/direction/PWM beat out.
// Steps in order: bit-serial gain multiply, a bound step, a bit-serial divide by 100
// and the output load. A new sample is accepted only once the previous beat is loaded,
// so the bit-serial gain multiply and divide set the pace; a held output beat stalls the load.
// Reset clears the stored error and integral and loads the register defaults.
module bidirectional_pid_pwm_drive (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bpd_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [bpd_pkg::GAIN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bpd_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bpd_pkg::out_item_t            out_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DUTY = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]                              state_q;
	logic [bpd_pkg::GAIN_W-1:0]              prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [bpd_pkg::THR_W-1:0]               cool_thr_q;
	logic signed [bpd_pkg::ERR_W-1:0]        prev_err_q;
	logic signed [bpd_pkg::INTEG_W-1:0]      integ_sum_q;
	logic signed [bpd_pkg::DERIV_W-1:0]      deriv_q;
	logic                                    halve_q;
	logic                                    neg_q;
	logic [bpd_pkg::DUTY_W-1:0]              duty_q;
	logic                                    out_valid_q;
	bpd_pkg::out_item_t                      out_q;

	logic                                    accept;
	logic signed [bpd_pkg::ERR_W-1:0]        err_c;
	logic signed [bpd_pkg::INTEG_W+1:0]      integ_raw;
	logic signed [bpd_pkg::INTEG_W-1:0]      integ_c;
	logic signed [bpd_pkg::DERIV_W-1:0]      deriv_c;
	logic signed [bpd_pkg::TEMP_W:0]         gap_diff;
	logic [bpd_pkg::TEMP_W:0]                gap_abs;

	logic                                    mac_last;
	logic signed [bpd_pkg::ACC_W-1:0]        acc;
	logic signed [bpd_pkg::ACC_W-1:0]        acc_neg;
	logic [bpd_pkg::MAG_W-1:0]               mag_c;
	logic [bpd_pkg::DUTY_W-1:0]              duty_c;

	logic                                    div_start;
	logic                                    div_last;
	logic [bpd_pkg::PWM_BITS-1:0]            quotient;
	logic                                    load_out;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// error, bounded integral, derivative and cooling gap, all at acceptance
	always_comb begin
		err_c = $signed({2'b00, in_data.setpoint, 8'h00})
			- $signed({2'b00, in_data.chamber_temp});
		integ_raw = (bpd_pkg::INTEG_W + 2)'(err_c)
			+ (bpd_pkg::INTEG_W + 2)'(integ_sum_q);
		if (integ_raw > bpd_pkg::INTEG_HI) begin
			integ_c = bpd_pkg::INTEG_HI[bpd_pkg::INTEG_W-1:0];
		end else if (integ_raw < bpd_pkg::INTEG_LO) begin
			integ_c = bpd_pkg::INTEG_LO[bpd_pkg::INTEG_W-1:0];
		end else begin
			integ_c = integ_raw[bpd_pkg::INTEG_W-1:0];
		end
		deriv_c = bpd_pkg::DERIV_W'(err_c) - bpd_pkg::DERIV_W'(prev_err_q);
		gap_diff = $signed({1'b0, in_data.chamber_temp}) - $signed({1'b0, in_data.sink_temp});
		if (gap_diff[bpd_pkg::TEMP_W]) begin
			gap_abs = $unsigned(-gap_diff);
		end else begin
			gap_abs = $unsigned(gap_diff);
		end
	end

	// bound the Q19.16 drive, take its magnitude in Q7.8 and halve it when cooling is limited
	always_comb begin
		acc_neg = -acc;
		if (acc > bpd_pkg::DRIVE_HI || acc < bpd_pkg::DRIVE_LO) begin
			mag_c = bpd_pkg::DRIVE_MAG;
		end else if (acc[bpd_pkg::ACC_W-1]) begin
			mag_c = acc_neg[bpd_pkg::MAG_W-1:0];
		end else begin
			mag_c = acc[bpd_pkg::MAG_W-1:0];
		end
		duty_c = mag_c[bpd_pkg::MAG_W-1:8];
		if (halve_q)
			duty_c = duty_c >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= bpd_pkg::PROP_GAIN_RST;
			integ_gain_q <= bpd_pkg::INTEG_GAIN_RST;
			deriv_gain_q <= bpd_pkg::DERIV_GAIN_RST;
			cool_thr_q   <= bpd_pkg::COOL_THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				bpd_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_wdata;
				bpd_pkg::REG_INTEG_GAIN: integ_gain_q <= cfg_wdata;
				bpd_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_wdata;
				bpd_pkg::REG_COOL_THR:   cool_thr_q   <= cfg_wdata[bpd_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			integ_sum_q <= '0;
		end else if (accept) begin
			prev_err_q  <= err_c;
			integ_sum_q <= integ_c;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deriv_q <= deriv_c;
			halve_q <= (in_data.setpoint < cool_thr_q) && (gap_abs > bpd_pkg::GAP_LIMIT);
		end
		if (state_q == ST_DUTY) begin
			duty_q <= duty_c;
			neg_q  <= acc[bpd_pkg::ACC_W-1];
		end
	end

	assign div_start = (state_q == ST_DUTY);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept)   state_q <= ST_MUL;
				ST_MUL:  if (mac_last) state_q <= ST_DUTY;
				ST_DUTY: state_q <= ST_DIV;
				ST_DIV:  if (div_last) state_q <= ST_DONE;
				ST_DONE: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.duty_magnitude  <= duty_q;
			out_q.drive_direction <= neg_q;
			if (neg_q) begin
				out_q.pwm_count <= quotient;
			end else begin
				out_q.pwm_count <= bpd_pkg::PWM_MAX - quotient;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bpd_serial_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.prop_gain  (prop_gain_q),
		.integ_gain (integ_gain_q),
		.deriv_gain (deriv_gain_q),
		.err        (prev_err_q),
		.integ      (integ_sum_q),
		.deriv      (deriv_q),
		.last       (mac_last),
		.acc        (acc)
	);

	bpd_pwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.duty     (duty_c),
		.last     (div_last),
		.quotient (quotient)
	);

endmodule
